// ----- rtl/core/amtq_pkg.sv -----
`timescale 1ns / 1ps

package amtq_pkg;

  // Q2.30 rotation and quaternion format
  localparam int unsigned QBITS = 30;

  // digit-by-digit square root of a 64-bit value
  localparam int unsigned SQRT_ITERS   = 32;
  localparam int unsigned SQRT_PER_STG = 2;
  localparam int unsigned SQRT_STGS    = (SQRT_ITERS + SQRT_PER_STG - 1) / SQRT_PER_STG;

  // restoring divider: quotient is at most 2^QBITS, so QBITS+1 quotient bits
  localparam int unsigned DIV_ITERS   = QBITS + 1;
  localparam int unsigned DIV_PER_STG = 2;
  localparam int unsigned DIV_STGS    = (DIV_ITERS + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int unsigned DVD_W       = 32 + QBITS;

  // sq, sum, root, div init, div, result ... twice, plus the 6-stage middle section
  localparam int unsigned LAT = 2 * (SQRT_STGS + DIV_STGS + 4) + 6;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sqrt_st_t;

  typedef struct packed {
    logic                 sgn;
    logic [31:0]          rem;
    logic [DIV_ITERS-1:0] low;
    logic [DIV_ITERS-1:0] quo;
  } div_st_t;

  function automatic sqrt_st_t sqrt_init(input logic [63:0] v);
    sqrt_st_t o;
    o.v = v;
    o.r = '0;
    return o;
  endfunction

  function automatic sqrt_st_t sqrt_stage(input sqrt_st_t s, input int unsigned stg);
    sqrt_st_t    o;
    logic [63:0] b;
    logic [63:0] t;
    o = s;
    for (int unsigned k = 0; k < SQRT_PER_STG; k++) begin
      if (stg * SQRT_PER_STG + k < SQRT_ITERS) begin
        b = 64'(1) << (62 - 2 * (stg * SQRT_PER_STG + k));
        t = o.r + b;
        if (o.v >= t) begin
          o.v = o.v - t;
          o.r = (o.r >> 1) + b;
        end else begin
          o.r = o.r >> 1;
        end
      end
    end
    return o;
  endfunction

  // dividend = |val| * 2^QBITS + den/2, for round half away from zero
  function automatic div_st_t div_init(input logic signed [31:0] val, input logic [31:0] den);
    div_st_t          o;
    logic [31:0]      mag;
    logic [DVD_W-1:0] dvd;
    mag   = val[31] ? 32'(-val) : 32'(val);
    dvd   = {mag, {QBITS{1'b0}}} + DVD_W'(den >> 1);
    o.sgn = val[31];
    o.rem = 32'(dvd[DVD_W-1:DIV_ITERS]);
    o.low = dvd[DIV_ITERS-1:0];
    o.quo = '0;
    return o;
  endfunction

  function automatic div_st_t div_stage(input div_st_t s, input logic [31:0] den,
                                        input int unsigned stg);
    div_st_t     o;
    logic [32:0] t;
    o = s;
    for (int unsigned k = 0; k < DIV_PER_STG; k++) begin
      if (stg * DIV_PER_STG + k < DIV_ITERS) begin
        t = {o.rem, o.low[DIV_ITERS-1]};
        if (t >= {1'b0, den}) begin
          o.rem = 32'(t - {1'b0, den});
          o.quo = {o.quo[DIV_ITERS-2:0], 1'b1};
        end else begin
          o.rem = t[31:0];
          o.quo = {o.quo[DIV_ITERS-2:0], 1'b0};
        end
        o.low = {o.low[DIV_ITERS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic signed [31:0] div_result(input div_st_t s);
    logic [31:0] q;
    q = 32'(s.quo);
    return s.sgn ? -q : q;
  endfunction

endpackage

// ----- rtl/core/affine_matrix_to_trs_quaternion_core.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | col0_x_i .. col3_z_i (Q16.16)
// out     | output    | out_valid_o / out_stall_i| ok_o, trans_*_o, quat_*_o (Q2.30), scale_*_o
//
// One matrix per cycle unless the output stalls; the pipeline depth is set by two square-root
// chains (32 steps) and two dividers (31 steps), each worked two steps per pipeline stage.
// rst_ni clears only the stage valid bits.
// A stalled output freezes the whole pipeline; in_stall_o follows out_stall_i when a
// result waits in the output register.
module affine_matrix_to_trs_quaternion_core
  import amtq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] col0_x_i,
  input  logic signed [31:0] col0_y_i,
  input  logic signed [31:0] col0_z_i,
  input  logic signed [31:0] col1_x_i,
  input  logic signed [31:0] col1_y_i,
  input  logic signed [31:0] col1_z_i,
  input  logic signed [31:0] col2_x_i,
  input  logic signed [31:0] col2_y_i,
  input  logic signed [31:0] col2_z_i,
  input  logic signed [31:0] col3_x_i,
  input  logic signed [31:0] col3_y_i,
  input  logic signed [31:0] col3_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic signed [31:0] trans_x_o,
  output logic signed [31:0] trans_y_o,
  output logic signed [31:0] trans_z_o,
  output logic signed [31:0] quat_x_o,
  output logic signed [31:0] quat_y_o,
  output logic signed [31:0] quat_z_o,
  output logic signed [31:0] quat_w_o,
  output logic signed [31:0] scale_x_o,
  output logic signed [31:0] scale_y_o,
  output logic signed [31:0] scale_z_o
);

  localparam logic signed [34:0] QONE_C = 35'(1) << QBITS;
  localparam logic [31:0]        SAT_C  = 32'h7FFF_FFFF;

  // round(v / 2^QBITS), half away from zero
  function automatic logic signed [33:0] shr_round(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = (mag + (64'(1) << (QBITS - 1))) >> QBITS;
    return v[63] ? -34'(q) : 34'(q);
  endfunction

  // C-style division by 4, truncating toward zero
  function automatic logic signed [31:0] div4(input logic signed [34:0] x);
    logic signed [34:0] y;
    y = x[34] ? (x + 35'sd3) >>> 2 : x >>> 2;
    return 32'(y);
  endfunction

  logic             adv;
  logic [LAT-1:0]   vld_q;

  logic signed [31:0] c_in [9];
  logic signed [31:0] t_in [3];

  assign c_in[0] = col0_x_i;
  assign c_in[1] = col0_y_i;
  assign c_in[2] = col0_z_i;
  assign c_in[3] = col1_x_i;
  assign c_in[4] = col1_y_i;
  assign c_in[5] = col1_z_i;
  assign c_in[6] = col2_x_i;
  assign c_in[7] = col2_y_i;
  assign c_in[8] = col2_z_i;
  assign t_in[0] = col3_x_i;
  assign t_in[1] = col3_y_i;
  assign t_in[2] = col3_z_i;

  assign adv        = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- column lengths
  logic signed [63:0] sq0_d [9];
  logic        [63:0] sq0_q [9];
  logic        [63:0] s1_d  [3];
  logic        [63:0] s1_q  [3];
  logic signed [31:0] cp_q  [SQRT_STGS+2][9];
  sqrt_st_t           sqa_d [SQRT_STGS][3];
  sqrt_st_t           sqa_q [SQRT_STGS][3];

  for (genvar i = 0; i < 9; i++) begin : g_sq0
    assign sq0_d[i] = 64'(c_in[i]) * 64'(c_in[i]);
  end

  for (genvar j = 0; j < 3; j++) begin : g_s1
    assign s1_d[j] = sq0_q[j*3] + sq0_q[j*3+1] + sq0_q[j*3+2];
  end

  for (genvar k = 0; k < SQRT_STGS; k++) begin : g_sqa
    for (genvar j = 0; j < 3; j++) begin : g_col
      if (k == 0) begin : g_first
        assign sqa_d[k][j] = sqrt_stage(sqrt_init(s1_q[j]), k);
      end else begin : g_next
        assign sqa_d[k][j] = sqrt_stage(sqa_q[k-1][j], k);
      end
    end
  end

  // ---------------------------------------------------------------- rotation entries
  div_st_t            dva_d  [DIV_STGS+1][9];
  div_st_t            dva_q  [DIV_STGS+1][9];
  logic        [31:0] lena_q [DIV_STGS+1][3];
  logic               oka_q  [DIV_STGS+1];
  logic        [31:0] len_root [3];

  for (genvar j = 0; j < 3; j++) begin : g_len
    assign len_root[j] = sqa_q[SQRT_STGS-1][j].r[31:0];
  end

  for (genvar i = 0; i < 9; i++) begin : g_dva
    assign dva_d[0][i] = div_init(cp_q[SQRT_STGS+1][i], len_root[i/3]);
    for (genvar k = 0; k < DIV_STGS; k++) begin : g_stg
      assign dva_d[k+1][i] = div_stage(dva_q[k][i], lena_q[k][i/3], k);
    end
  end

  // lanes are col*3 + row
  logic signed [31:0] r35_q [9];
  logic        [31:0] len35_q [3];
  logic               ok35_q;

  // ---------------------------------------------------------------- determinant sign
  logic signed [63:0] p36_d [6];
  logic signed [63:0] p36_q [6];
  logic signed [31:0] r36_q [9];
  logic        [31:0] len36_q [3];
  logic               ok36_q;
  logic signed [33:0] cof37_d [3];
  logic signed [33:0] cof37_q [3];
  logic signed [31:0] r37_q [9];
  logic        [31:0] len37_q [3];
  logic               ok37_q;
  logic signed [63:0] dp38_d [3];
  logic signed [63:0] dp38_q [3];
  logic signed [31:0] r38_q [9];
  logic        [31:0] len38_q [3];
  logic               ok38_q;
  logic        [2:0]  mir39_d;
  logic        [2:0]  mir39_q;
  logic signed [31:0] r39_q [9];
  logic        [31:0] len39_q [3];
  logic               ok39_q;

  assign p36_d[0] = 64'(r35_q[4]) * 64'(r35_q[8]);
  assign p36_d[1] = 64'(r35_q[7]) * 64'(r35_q[5]);
  assign p36_d[2] = 64'(r35_q[1]) * 64'(r35_q[8]);
  assign p36_d[3] = 64'(r35_q[7]) * 64'(r35_q[2]);
  assign p36_d[4] = 64'(r35_q[1]) * 64'(r35_q[5]);
  assign p36_d[5] = 64'(r35_q[4]) * 64'(r35_q[2]);

  for (genvar k = 0; k < 3; k++) begin : g_cof
    assign cof37_d[k] = shr_round(p36_q[2*k] - p36_q[2*k+1]);
    assign dp38_d[k]  = 64'(r37_q[k*3]) * 64'(cof37_q[k]);
  end

  always_comb begin : mirror_sel
    logic signed [63:0] det;
    det     = dp38_q[0] - dp38_q[1] + dp38_q[2];
    mir39_d = '0;
    if (det[63]) begin
      priority if (len38_q[0] <= len38_q[1] && len38_q[0] <= len38_q[2]) begin
        mir39_d = 3'b001;
      end else if (len38_q[1] <= len38_q[0] && len38_q[1] <= len38_q[2]) begin
        mir39_d = 3'b010;
      end else begin
        mir39_d = 3'b100;
      end
    end
  end

  // ---------------------------------------------------------------- mirror, Shepperd
  logic signed [31:0] r40_d  [9];
  logic signed [31:0] r40_q  [9];
  logic signed [31:0] scl40_d [3];
  logic signed [31:0] scl40_q [3];
  logic               ok40_q;

  for (genvar i = 0; i < 9; i++) begin : g_mir
    assign r40_d[i] = mir39_q[i/3] ? -r39_q[i] : r39_q[i];
  end

  for (genvar j = 0; j < 3; j++) begin : g_scl
    logic [31:0] sat;
    assign sat        = (len39_q[j] > SAT_C) ? SAT_C : len39_q[j];
    assign scl40_d[j] = mir39_q[j] ? -sat : sat;
  end

  logic signed [31:0] cmp41_d [4];
  logic signed [31:0] cmp41_q [4];
  logic signed [31:0] scl41_q [3];
  logic               ok41_q;

  always_comb begin : shepperd
    logic signed [34:0] a00, a10, a20, a01, a11, a21, a02, a12, a22, tr;
    logic signed [34:0] cx, cy, cz, cw;
    a00 = 35'(r40_q[0]);
    a10 = 35'(r40_q[1]);
    a20 = 35'(r40_q[2]);
    a01 = 35'(r40_q[3]);
    a11 = 35'(r40_q[4]);
    a21 = 35'(r40_q[5]);
    a02 = 35'(r40_q[6]);
    a12 = 35'(r40_q[7]);
    a22 = 35'(r40_q[8]);
    tr  = a00 + a11 + a22;
    priority if (tr > 0) begin
      cw = tr + QONE_C;
      cx = a21 - a12;
      cy = a02 - a20;
      cz = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      cx = QONE_C + a00 - a11 - a22;
      cw = a21 - a12;
      cy = a01 + a10;
      cz = a02 + a20;
    end else if (a11 > a22) begin
      cy = QONE_C + a11 - a00 - a22;
      cw = a02 - a20;
      cx = a01 + a10;
      cz = a12 + a21;
    end else begin
      cz = QONE_C + a22 - a00 - a11;
      cw = a10 - a01;
      cx = a02 + a20;
      cy = a12 + a21;
    end
    cmp41_d[0] = div4(cx);
    cmp41_d[1] = div4(cy);
    cmp41_d[2] = div4(cz);
    cmp41_d[3] = div4(cw);
  end

  // ---------------------------------------------------------------- quaternion norm
  logic signed [63:0] csq42_d [4];
  logic        [63:0] csq42_q [4];
  logic signed [31:0] cmp42_q [4];
  logic signed [31:0] scl42_q [3];
  logic               ok42_q;
  logic        [63:0] sum43_q;
  logic signed [31:0] cmp43_q [4];
  logic signed [31:0] scl43_q [3];
  logic               ok43_q;

  for (genvar k = 0; k < 4; k++) begin : g_csq
    assign csq42_d[k] = 64'(cmp41_q[k]) * 64'(cmp41_q[k]);
  end

  sqrt_st_t           sqb_d  [SQRT_STGS];
  sqrt_st_t           sqb_q  [SQRT_STGS];
  logic signed [31:0] cmpb_q [SQRT_STGS][4];
  logic signed [31:0] sclb_q [SQRT_STGS][3];
  logic               okb_q  [SQRT_STGS];

  for (genvar k = 0; k < SQRT_STGS; k++) begin : g_sqb
    if (k == 0) begin : g_first
      assign sqb_d[k] = sqrt_stage(sqrt_init(sum43_q), k);
    end else begin : g_next
      assign sqb_d[k] = sqrt_stage(sqb_q[k-1], k);
    end
  end

  logic        [31:0] n_root;
  div_st_t            dvb_d  [DIV_STGS+1][4];
  div_st_t            dvb_q  [DIV_STGS+1][4];
  logic        [31:0] nb_q   [DIV_STGS+1];
  logic signed [31:0] sclc_q [DIV_STGS+1][3];
  logic               okc_q  [DIV_STGS+1];

  assign n_root = sqb_q[SQRT_STGS-1].r[31:0];

  for (genvar i = 0; i < 4; i++) begin : g_dvb
    assign dvb_d[0][i] = div_init(cmpb_q[SQRT_STGS-1][i], n_root);
    for (genvar k = 0; k < DIV_STGS; k++) begin : g_stg
      assign dvb_d[k+1][i] = div_stage(dvb_q[k][i], nb_q[k], k);
    end
  end

  logic signed [31:0] trd_q [LAT-1][3];

  // ---------------------------------------------------------------- stage registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        sq0_q[i]    <= sq0_d[i];
        cp_q[0][i]  <= c_in[i];
        for (int k = 1; k < SQRT_STGS + 2; k++) cp_q[k][i] <= cp_q[k-1][i];
      end
      for (int j = 0; j < 3; j++) begin
        s1_q[j]  <= s1_d[j];
        trd_q[0][j] <= t_in[j];
        for (int k = 1; k < LAT - 1; k++) trd_q[k][j] <= trd_q[k-1][j];
        for (int k = 0; k < SQRT_STGS; k++) sqa_q[k][j] <= sqa_d[k][j];
      end

      for (int k = 0; k < DIV_STGS + 1; k++) begin
        for (int i = 0; i < 9; i++) dva_q[k][i] <= dva_d[k][i];
      end
      for (int j = 0; j < 3; j++) lena_q[0][j] <= len_root[j];
      oka_q[0] <= (len_root[0] != '0) && (len_root[1] != '0) && (len_root[2] != '0);
      for (int k = 1; k < DIV_STGS + 1; k++) begin
        lena_q[k] <= lena_q[k-1];
        oka_q[k]  <= oka_q[k-1];
      end

      for (int i = 0; i < 9; i++) begin
        r35_q[i] <= div_result(dva_q[DIV_STGS][i]);
        r36_q[i] <= r35_q[i];
        r37_q[i] <= r36_q[i];
        r38_q[i] <= r37_q[i];
        r39_q[i] <= r38_q[i];
        r40_q[i] <= r40_d[i];
      end
      len35_q <= lena_q[DIV_STGS];
      len36_q <= len35_q;
      len37_q <= len36_q;
      len38_q <= len37_q;
      len39_q <= len38_q;
      ok35_q  <= oka_q[DIV_STGS];
      ok36_q  <= ok35_q;
      ok37_q  <= ok36_q;
      ok38_q  <= ok37_q;
      ok39_q  <= ok38_q;
      ok40_q  <= ok39_q;
      ok41_q  <= ok40_q;
      ok42_q  <= ok41_q;
      ok43_q  <= ok42_q;
      p36_q   <= p36_d;
      cof37_q <= cof37_d;
      dp38_q  <= dp38_d;
      mir39_q <= mir39_d;
      scl40_q <= scl40_d;
      scl41_q <= scl40_q;
      scl42_q <= scl41_q;
      scl43_q <= scl42_q;
      cmp41_q <= cmp41_d;
      cmp42_q <= cmp41_q;
      cmp43_q <= cmp42_q;
      for (int k = 0; k < 4; k++) csq42_q[k] <= csq42_d[k];
      sum43_q <= csq42_q[0] + csq42_q[1] + csq42_q[2] + csq42_q[3];

      for (int k = 0; k < SQRT_STGS; k++) sqb_q[k] <= sqb_d[k];
      cmpb_q[0] <= cmp43_q;
      sclb_q[0] <= scl43_q;
      okb_q[0]  <= ok43_q;
      for (int k = 1; k < SQRT_STGS; k++) begin
        cmpb_q[k] <= cmpb_q[k-1];
        sclb_q[k] <= sclb_q[k-1];
        okb_q[k]  <= okb_q[k-1];
      end

      for (int k = 0; k < DIV_STGS + 1; k++) begin
        for (int i = 0; i < 4; i++) dvb_q[k][i] <= dvb_d[k][i];
      end
      nb_q[0]   <= n_root;
      sclc_q[0] <= sclb_q[SQRT_STGS-1];
      okc_q[0]  <= okb_q[SQRT_STGS-1] && (n_root != '0);
      for (int k = 1; k < DIV_STGS + 1; k++) begin
        nb_q[k]   <= nb_q[k-1];
        sclc_q[k] <= sclc_q[k-1];
        okc_q[k]  <= okc_q[k-1];
      end

      // output register: degenerate matrices give all zeros
      ok_o      <= okc_q[DIV_STGS];
      trans_x_o <= okc_q[DIV_STGS] ? trd_q[LAT-2][0] : '0;
      trans_y_o <= okc_q[DIV_STGS] ? trd_q[LAT-2][1] : '0;
      trans_z_o <= okc_q[DIV_STGS] ? trd_q[LAT-2][2] : '0;
      quat_x_o  <= okc_q[DIV_STGS] ? div_result(dvb_q[DIV_STGS][0]) : '0;
      quat_y_o  <= okc_q[DIV_STGS] ? div_result(dvb_q[DIV_STGS][1]) : '0;
      quat_z_o  <= okc_q[DIV_STGS] ? div_result(dvb_q[DIV_STGS][2]) : '0;
      quat_w_o  <= okc_q[DIV_STGS] ? div_result(dvb_q[DIV_STGS][3]) : '0;
      scale_x_o <= okc_q[DIV_STGS] ? sclc_q[DIV_STGS][0] : '0;
      scale_y_o <= okc_q[DIV_STGS] ? sclc_q[DIV_STGS][1] : '0;
      scale_z_o <= okc_q[DIV_STGS] ? sclc_q[DIV_STGS][2] : '0;
    end
  end

  assign out_valid_o = vld_q[LAT-1];

  // ---------------------------------------------------------------- assertions
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> quat_w_o == 0 && scale_x_o == 0 && trans_x_o == 0)
    else $error("degenerate result carries non-zero fields");

  a_quat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> quat_w_o <= 32'sh4000_0000 && quat_w_o >= -32'sh4000_0000
                         && quat_x_o <= 32'sh4000_0000 && quat_x_o >= -32'sh4000_0000)
    else $error("quaternion component outside unit range");

  a_scale_nz : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> scale_x_o != 0 && scale_y_o != 0 && scale_z_o != 0)
    else $error("successful result with zero scale");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

endmodule

// ----- tb/affine_matrix_to_trs_quaternion_core_test.sv -----
`timescale 1ns / 1ps

module affine_matrix_to_trs_quaternion_core_test;
  import amtq_pkg::*;

  localparam longint QONE = 64'sd1 << QBITS;

  typedef struct {
    logic signed [31:0] col[4][3];
  } matrix_t;

  typedef struct {
    logic               ok;
    logic signed [31:0] trans[3];
    logic signed [31:0] quat[4];
    logic signed [31:0] scale[3];
  } trs_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] col_i[4][3];
  logic               out_valid_o;
  logic               out_stall_i;
  logic               ok_o;
  logic signed [31:0] trans_o[3];
  logic signed [31:0] quat_o[4];
  logic signed [31:0] scale_o[3];

  trs_t expected_trs[$];
  int   idle_pct;
  int   hold_left;
  int   n_errors;
  int   n_sent;
  int   n_checked;
  int   n_degenerate;
  int   n_mirrored;

  affine_matrix_to_trs_quaternion_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .col0_x_i   (col_i[0][0]),
    .col0_y_i   (col_i[0][1]),
    .col0_z_i   (col_i[0][2]),
    .col1_x_i   (col_i[1][0]),
    .col1_y_i   (col_i[1][1]),
    .col1_z_i   (col_i[1][2]),
    .col2_x_i   (col_i[2][0]),
    .col2_y_i   (col_i[2][1]),
    .col2_z_i   (col_i[2][2]),
    .col3_x_i   (col_i[3][0]),
    .col3_y_i   (col_i[3][1]),
    .col3_z_i   (col_i[3][2]),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .trans_x_o  (trans_o[0]),
    .trans_y_o  (trans_o[1]),
    .trans_z_o  (trans_o[2]),
    .quat_x_o   (quat_o[0]),
    .quat_y_o   (quat_o[1]),
    .quat_z_o   (quat_o[2]),
    .quat_w_o   (quat_o[3]),
    .scale_x_o  (scale_o[0]),
    .scale_y_o  (scale_o[1]),
    .scale_z_o  (scale_o[2])
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // round half away from zero
  function automatic longint div_away(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = num < 0 ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint q30_round(longint v);
    longint unsigned mag;
    longint unsigned q;
    mag = v < 0 ? longint'(-v) : v;
    q = (mag + (64'd1 << (QBITS - 1))) >> QBITS;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic trs_t decompose_affine(matrix_t mx);
    trs_t            res;
    longint          cc[3][3];
    longint unsigned len[3];
    longint          rot[3][3];
    longint          sc[3];
    longint          qc[4];
    longint          det;
    longint          tr;
    longint unsigned sumsq;
    longint unsigned nrm;
    int              mir;
    res.ok = 1'b0;
    foreach (res.trans[i]) res.trans[i] = '0;
    foreach (res.quat[i]) res.quat[i] = '0;
    foreach (res.scale[i]) res.scale[i] = '0;
    for (int j = 0; j < 3; j++) begin
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        cc[j][i] = mx.col[j][i];
        sumsq += longint'(cc[j][i] * cc[j][i]);
      end
      len[j] = int_sqrt(sumsq);
      if (len[j] == 0) return res;
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) rot[i][j] = div_away(cc[j][i] * QONE, len[j]);
      sc[j] = len[j] > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(len[j]);
    end
    det = rot[0][0] * q30_round(rot[1][1] * rot[2][2] - rot[1][2] * rot[2][1])
        - rot[0][1] * q30_round(rot[1][0] * rot[2][2] - rot[1][2] * rot[2][0])
        + rot[0][2] * q30_round(rot[1][0] * rot[2][1] - rot[1][1] * rot[2][0]);
    if (det < 0) begin
      if (len[0] <= len[1] && len[0] <= len[2]) mir = 0;
      else if (len[1] <= len[2]) mir = 1;
      else mir = 2;
      sc[mir] = -sc[mir];
      for (int i = 0; i < 3; i++) rot[i][mir] = -rot[i][mir];
    end
    tr = rot[0][0] + rot[1][1] + rot[2][2];
    if (tr > 0) begin
      qc[3] = tr + QONE;
      qc[0] = rot[2][1] - rot[1][2];
      qc[1] = rot[0][2] - rot[2][0];
      qc[2] = rot[1][0] - rot[0][1];
    end else if (rot[0][0] > rot[1][1] && rot[0][0] > rot[2][2]) begin
      qc[0] = QONE + rot[0][0] - rot[1][1] - rot[2][2];
      qc[3] = rot[2][1] - rot[1][2];
      qc[1] = rot[0][1] + rot[1][0];
      qc[2] = rot[0][2] + rot[2][0];
    end else if (rot[1][1] > rot[2][2]) begin
      qc[1] = QONE + rot[1][1] - rot[0][0] - rot[2][2];
      qc[3] = rot[0][2] - rot[2][0];
      qc[0] = rot[0][1] + rot[1][0];
      qc[2] = rot[1][2] + rot[2][1];
    end else begin
      qc[2] = QONE + rot[2][2] - rot[0][0] - rot[1][1];
      qc[3] = rot[1][0] - rot[0][1];
      qc[0] = rot[0][2] + rot[2][0];
      qc[1] = rot[1][2] + rot[2][1];
    end
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      qc[i] = qc[i] / 4;
      sumsq += longint'(qc[i] * qc[i]);
    end
    nrm = int_sqrt(sumsq);
    if (nrm == 0) return res;
    res.ok = 1'b1;
    for (int i = 0; i < 3; i++) res.trans[i] = mx.col[3][i];
    for (int i = 0; i < 4; i++) res.quat[i] = 32'(div_away(qc[i] * QONE, nrm));
    for (int i = 0; i < 3; i++) res.scale[i] = 32'(sc[i]);
    return res;
  endfunction

  task automatic send_matrix(matrix_t mx);
    trs_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    col_i      <= mx.col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = decompose_affine(mx);
    if (!res.ok) n_degenerate++;
    if (res.scale[0] < 0 || res.scale[1] < 0 || res.scale[2] < 0) n_mirrored++;
    expected_trs.push_back(res);
    n_sent++;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'(int'($urandom_range(2 * 65536)) - 65536);
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // scaled rotation, possibly mirrored, with a little noise
  function automatic matrix_t rand_pose();
    matrix_t mx;
    real     qa[4];
    real     nq;
    real     rm[3][3];
    real     s;
    for (int i = 0; i < 4; i++) qa[i] = real'(int'($urandom_range(2000)) - 1000);
    nq = $sqrt(qa[0]*qa[0] + qa[1]*qa[1] + qa[2]*qa[2] + qa[3]*qa[3]);
    if (nq < 1.0) begin
      qa[3] = 1.0;
      nq = 1.0;
    end
    for (int i = 0; i < 4; i++) qa[i] = qa[i] / nq;
    rm[0][0] = 1.0 - 2.0 * (qa[1]*qa[1] + qa[2]*qa[2]);
    rm[0][1] = 2.0 * (qa[0]*qa[1] - qa[2]*qa[3]);
    rm[0][2] = 2.0 * (qa[0]*qa[2] + qa[1]*qa[3]);
    rm[1][0] = 2.0 * (qa[0]*qa[1] + qa[2]*qa[3]);
    rm[1][1] = 1.0 - 2.0 * (qa[0]*qa[0] + qa[2]*qa[2]);
    rm[1][2] = 2.0 * (qa[1]*qa[2] - qa[0]*qa[3]);
    rm[2][0] = 2.0 * (qa[0]*qa[2] - qa[1]*qa[3]);
    rm[2][1] = 2.0 * (qa[1]*qa[2] + qa[0]*qa[3]);
    rm[2][2] = 1.0 - 2.0 * (qa[0]*qa[0] + qa[1]*qa[1]);
    for (int j = 0; j < 3; j++) begin
      s = real'($urandom_range(1, 30000)) * 65536.0 / real'($urandom_range(1, 1000));
      if ($urandom_range(3) == 0) s = -s;
      for (int i = 0; i < 3; i++)
        mx.col[j][i] = 32'($rtoi(rm[i][j] * s) + int'($urandom_range(8)) - 4);
    end
    for (int i = 0; i < 3; i++) mx.col[3][i] = $urandom();
    return mx;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t mx;
    int      r;
    r = $urandom_range(99);
    if (r < 70) begin
      mx = rand_pose();
    end else begin
      foreach (mx.col[j, i]) mx.col[j][i] = rand_word();
    end
    if ($urandom_range(49) == 0) begin
      r = $urandom_range(2);
      for (int i = 0; i < 3; i++) mx.col[r][i] = '0;
    end
    return mx;
  endfunction

  function automatic matrix_t diag_matrix(logic signed [31:0] a, logic signed [31:0] b,
                                          logic signed [31:0] c);
    matrix_t mx;
    foreach (mx.col[j, i]) mx.col[j][i] = '0;
    mx.col[0][0] = a;
    mx.col[1][1] = b;
    mx.col[2][2] = c;
    return mx;
  endfunction

  task automatic test_directed();
    matrix_t mx;
    send_matrix(diag_matrix(32'sh10000, 32'sh10000, 32'sh10000));
    // equal lengths, mirrored: x axis is the one negated
    send_matrix(diag_matrix(-32'sh10000, -32'sh10000, -32'sh10000));
    send_matrix(diag_matrix(32'sh30000, -32'sh8000, 32'sh20000));
    // half-turns select the x, y and z branches
    send_matrix(diag_matrix(32'sh10000, -32'sh10000, -32'sh10000));
    send_matrix(diag_matrix(-32'sh10000, 32'sh10000, -32'sh10000));
    send_matrix(diag_matrix(-32'sh10000, -32'sh10000, 32'sh10000));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1));
    foreach (mx.col[j, i]) mx.col[j][i] = 32'sh8000_0000;
    send_matrix(mx);
    foreach (mx.col[j, i]) mx.col[j][i] = 32'sh7FFF_FFFF;
    send_matrix(mx);
    // scale saturation on every axis
    mx = diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    mx.col[0][1] = 32'sh8000_0000;
    mx.col[1][2] = 32'sh7FFF_FFFF;
    mx.col[2][0] = 32'sh8000_0000;
    send_matrix(mx);
    for (int z = 0; z < 3; z++) begin
      mx = diag_matrix(32'sh10000, 32'sh20000, 32'sh30000);
      for (int i = 0; i < 3; i++) mx.col[z][i] = '0;
      mx.col[3][z] = 32'sh7FFF_FFFF;
      send_matrix(mx);
    end
    foreach (mx.col[j, i]) mx.col[j][i] = '0;
    send_matrix(mx);
    // rotations by a quarter turn about each axis
    mx = diag_matrix(32'sh10000, 0, 0);
    mx.col[1][2] = 32'sh10000;
    mx.col[2][1] = -32'sh10000;
    send_matrix(mx);
    mx = diag_matrix(0, 32'sh10000, 0);
    mx.col[0][2] = -32'sh10000;
    mx.col[2][0] = 32'sh10000;
    send_matrix(mx);
    mx = diag_matrix(0, 0, 32'sh10000);
    mx.col[0][1] = 32'sh10000;
    mx.col[1][0] = -32'sh10000;
    mx.col[3][0] = 32'sh8000_0000;
    mx.col[3][1] = 32'sh7FFF_FFFF;
    mx.col[3][2] = -32'sh1;
    send_matrix(mx);
    send_matrix(diag_matrix(32'sh1, 32'sh1, -32'sh1));
    for (int k = 0; k < 4; k++) send_matrix(rand_pose());
  endtask

  task automatic test_random(int count);
    repeat (count) send_matrix(rand_matrix());
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    repeat (250) send_matrix(rand_matrix());
    idle_pct = 13;
  endtask

  task automatic test_output_holdoff();
    hold_left = 300;
    repeat (150) send_matrix(rand_matrix());
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= idle_pct > 0 && $urandom_range(99) < idle_pct;
    end
  end

  function automatic void check_word(string name, logic signed [31:0] exp_v,
                                     logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d (%h) actual %0d (%h)", $time, name, exp_v, exp_v,
               act_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    trs_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_trs.size() == 0) begin
        $display("%0t: unexpected transaction at output", $time);
        n_errors++;
      end else begin
        exp_r = expected_trs.pop_front();
        n_checked++;
        if (exp_r.ok !== ok_o) begin
          $display("%0t: ok expected %0b actual %0b", $time, exp_r.ok, ok_o);
          n_errors++;
        end
        check_word("trans_x", exp_r.trans[0], trans_o[0]);
        check_word("trans_y", exp_r.trans[1], trans_o[1]);
        check_word("trans_z", exp_r.trans[2], trans_o[2]);
        check_word("quat_x", exp_r.quat[0], quat_o[0]);
        check_word("quat_y", exp_r.quat[1], quat_o[1]);
        check_word("quat_z", exp_r.quat[2], quat_o[2]);
        check_word("quat_w", exp_r.quat[3], quat_o[3]);
        check_word("scale_x", exp_r.scale[0], scale_o[0]);
        check_word("scale_y", exp_r.scale[1], scale_o[1]);
        check_word("scale_z", exp_r.scale[2], scale_o[2]);
      end
    end
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int wait_cycles;
    idle_pct     = 0;
    hold_left    = 0;
    n_errors     = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_degenerate = 0;
    n_mirrored   = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_stall_i  = 1'b0;
    foreach (col_i[j, i]) col_i[j][i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 13;
    test_directed();
    test_random(300);
    test_back_to_back();
    test_output_holdoff();
    test_random(380);
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (expected_trs.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LAT + 20) @(posedge clk_i);
    $display("%0d matrices sent, %0d results checked (%0d degenerate, %0d mirrored)",
             n_sent, n_checked, n_degenerate, n_mirrored);
    $display("covered: directed corners, random poses and raw words, back-to-back and hold-off");
    if (n_errors == 0 && expected_trs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_trs.size() != 0) $display("%0d results never arrived", expected_trs.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
